FILE: rtl/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types, codes and defaults for the keyed stack with search.
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam int unsigned DEF_STACK_DEPTH = 16;
    localparam int unsigned DEF_KEY_BITS    = 16;

    localparam int unsigned IN_KEY_BITS = 16;
    localparam int unsigned QTY_BITS    = 16;
    localparam int unsigned STATUS_BITS = 2;
    localparam int unsigned ACTION_BITS = 2;
    localparam int unsigned CODE_BITS   = 2;
    localparam int unsigned HELD_BITS   = 5;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_UPDATE = 2'd1,
        ACT_POP    = 2'd2,
        ACT_LOOKUP = 2'd3
    } t_action;

    typedef enum logic [CODE_BITS-1:0] {
        RES_OK        = 2'd0,
        RES_NOT_FOUND = 2'd1,
        RES_FULL      = 2'd2
    } t_code;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEARCH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic  load;
        logic  rd;
        logic  push_wr;
        logic  upd_wr;
        logic  pop_dec;
        logic  respond;
        logic  found_sel;
        t_code code;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_action action;
        logic    empty;
        logic    full;
        logic    left_zero;
        logic    cmp_vld;
        logic    hit;
    } t_dp_stat;

endpackage

FILE: rtl/kss_ram.sv
// ----------------------------------------------------------------------------
// kss_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kss_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/kss_ctrl.sv
// ----------------------------------------------------------------------------
// kss_ctrl
// Command sequencer: dispatches push, and any command on an empty stack, directly; walks the stack for the rest.
// ----------------------------------------------------------------------------
module kss_ctrl
    import kss_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    w_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_stat.action == ACT_PUSH) begin
                    w_cmd.respond = 1'b1;
                    n_state       = ST_IDLE;
                    if (i_stat.full) begin
                        w_cmd.code = RES_FULL;
                    end else begin
                        w_cmd.push_wr = 1'b1;
                        w_cmd.code    = RES_OK;
                    end
                end else if (i_stat.empty) begin
                    w_cmd.respond = 1'b1;
                    w_cmd.code    = RES_NOT_FOUND;
                    n_state       = ST_IDLE;
                end else begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // one read issued per cycle while entries remain, compared once its data is registered
                w_cmd.rd = !i_stat.left_zero;
                if (i_stat.cmp_vld) begin
                    if (i_stat.hit) begin
                        w_cmd.respond = 1'b1;
                        w_cmd.code    = RES_OK;
                        n_state       = ST_IDLE;
                        case (i_stat.action)
                            ACT_UPDATE: w_cmd.upd_wr    = 1'b1;
                            ACT_POP:    w_cmd.pop_dec   = 1'b1;
                            ACT_LOOKUP: w_cmd.found_sel = 1'b1;
                            default:    ;
                        endcase
                    end else if (i_stat.action == ACT_POP || i_stat.left_zero) begin
                        // pop only checks the top entry
                        w_cmd.respond = 1'b1;
                        w_cmd.code    = RES_NOT_FOUND;
                        n_state       = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != ST_IDLE);

endmodule

FILE: rtl/kss_dp.sv
// ----------------------------------------------------------------------------
// kss_dp
// Datapath: entry store, fill count, search pointer and result registers.
// ----------------------------------------------------------------------------
module kss_dp
    import kss_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int unsigned KEY_BITS    = DEF_KEY_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic [ACTION_BITS-1:0] i_action,
    input  logic [IN_KEY_BITS-1:0] i_entry_key,
    input  logic [QTY_BITS-1:0]    i_entry_quantity,
    input  logic [STATUS_BITS-1:0] i_entry_status,
    output logic                   o_valid,
    output logic [CODE_BITS-1:0]   o_result_code,
    output logic [QTY_BITS-1:0]    o_found_quantity,
    output logic [STATUS_BITS-1:0] o_found_status,
    output logic [HELD_BITS-1:0]   o_entries_held
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned FW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned EW = KEY_BITS + QTY_BITS + STATUS_BITS;

    logic [FW-1:0]          r_fill;
    logic [FW-1:0]          n_fill;
    logic [AW-1:0]          r_ptr;
    logic [FW-1:0]          r_left;
    logic                   r_cmp_vld;
    logic [AW-1:0]          r_cmp_ptr;
    t_action                r_action;
    logic [KEY_BITS-1:0]    r_key;
    logic [QTY_BITS-1:0]    r_qty;
    logic [STATUS_BITS-1:0] r_status;

    logic                   r_valid;
    logic [CODE_BITS-1:0]   r_code;
    logic [QTY_BITS-1:0]    r_fq;
    logic [STATUS_BITS-1:0] r_fs;
    logic [HELD_BITS-1:0]   r_held;

    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [EW-1:0]          w_wdata;
    logic [EW-1:0]          w_rdata;
    logic [KEY_BITS-1:0]    w_rd_key;
    logic [QTY_BITS-1:0]    w_rd_qty;
    logic [STATUS_BITS-1:0] w_rd_st;
    logic                   w_hit;

    assign w_rd_key = w_rdata[EW-1 -: KEY_BITS];
    assign w_rd_qty = w_rdata[STATUS_BITS +: QTY_BITS];
    assign w_rd_st  = w_rdata[STATUS_BITS-1:0];
    assign w_hit    = r_cmp_vld && (w_rd_key == r_key);

    // push writes a new top, update rewrites the matched entry's status
    assign w_we    = i_cmd.push_wr || i_cmd.upd_wr;
    assign w_waddr = i_cmd.push_wr ? AW'(r_fill) : r_cmp_ptr;
    assign w_wdata = i_cmd.push_wr ? {r_key, r_qty, r_status}
                                   : {w_rd_key, w_rd_qty, r_status};

    kss_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.push_wr) begin
            n_fill = r_fill + FW'(1);
        end else if (i_cmd.pop_dec) begin
            n_fill = r_fill - FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_cmp_vld <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_fill    <= n_fill;
            r_cmp_vld <= i_cmd.rd;
            r_valid   <= i_cmd.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_key    <= KEY_BITS'(i_entry_key);
            r_qty    <= i_entry_quantity;
            r_status <= i_entry_status;
            r_ptr    <= AW'(r_fill - FW'(1));
            r_left   <= r_fill;
        end else if (i_cmd.rd) begin
            r_ptr     <= r_ptr - AW'(1);
            r_left    <= r_left - FW'(1);
            r_cmp_ptr <= r_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            r_code <= i_cmd.code;
            r_fq   <= i_cmd.found_sel ? w_rd_qty : '0;
            r_fs   <= i_cmd.found_sel ? w_rd_st : '0;
            r_held <= HELD_BITS'(n_fill);
        end
    end

    assign o_stat.action    = r_action;
    assign o_stat.empty     = (r_fill == '0);
    assign o_stat.full      = (r_fill == FW'(STACK_DEPTH));
    assign o_stat.left_zero = (r_left == '0);
    assign o_stat.cmp_vld   = r_cmp_vld;
    assign o_stat.hit       = w_hit;

    assign o_valid          = r_valid;
    assign o_result_code    = r_code;
    assign o_found_quantity = r_fq;
    assign o_found_status   = r_fs;
    assign o_entries_held   = r_held;

endmodule

FILE: rtl/keyed_stack_with_search.sv
// ----------------------------------------------------------------------------
// keyed_stack_with_search
// Bounded stack of keyed entries with top-down associative search.
// ----------------------------------------------------------------------------
// A command (action, key, quantity, status) is taken on a rising edge where
// start is high and busy is low. Each command gives exactly one result item,
// shown on the o_ result ports for one cycle with o_valid high; the receiver
// cannot hold it off. busy drops in the cycle the result is shown, so the
// next command may be taken right then.
// Path from acceptance to o_valid:
//   push, or any command on an empty stack: answered from the dispatch state
//   pop: the top entry is read and compared, then answered
//   lookup / update: entries are read from the top down until the first match,
//   or until every entry held has been compared when nothing matches.
// The walk reads one entry per cycle from a single read port of the entry
// store, so a full search of STACK_DEPTH entries sets the worst case.
// Reset empties the stack; the entry store itself is not cleared, only
// entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module keyed_stack_with_search
    import kss_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int unsigned KEY_BITS    = DEF_KEY_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ACTION_BITS-1:0] i_action,
    input  logic [IN_KEY_BITS-1:0] i_entry_key,
    input  logic [QTY_BITS-1:0]    i_entry_quantity,
    input  logic [STATUS_BITS-1:0] i_entry_status,
    output logic                   o_valid,
    output logic [CODE_BITS-1:0]   o_result_code,
    output logic [QTY_BITS-1:0]    o_found_quantity,
    output logic [STATUS_BITS-1:0] o_found_status,
    output logic [HELD_BITS-1:0]   o_entries_held
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    kss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    kss_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_action         (i_action),
        .i_entry_key      (i_entry_key),
        .i_entry_quantity (i_entry_quantity),
        .i_entry_status   (i_entry_status),
        .o_valid          (o_valid),
        .o_result_code    (o_result_code),
        .o_found_quantity (o_found_quantity),
        .o_found_status   (o_found_status),
        .o_entries_held   (o_entries_held)
    );

endmodule

FILE: tb/sv/keyed_stack_with_search_tb.sv
// ----------------------------------------------------------------------------
// keyed_stack_with_search_tb
// Self-checking bench for the keyed stack: push, pop-if-top, update and
// lookup items are sent through the start/busy handshake, a shadow stack
// predicts each answer, and every o_valid result is compared field by field.
// ----------------------------------------------------------------------------
module keyed_stack_with_search_tb
    import kss_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH       = DEF_STACK_DEPTH;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned TAIL_CYCLES = DEPTH + 8;
    localparam logic [IN_KEY_BITS-1:0] KEY_MASK =
        IN_KEY_BITS'((64'd1 << DEF_KEY_BITS) - 1);

    typedef struct packed {
        t_code                  code;
        logic [QTY_BITS-1:0]    qty;
        logic [STATUS_BITS-1:0] status;
        logic [HELD_BITS-1:0]   held;
    } t_answer;

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   start            = 1'b0;
    logic                   busy;
    logic [ACTION_BITS-1:0] i_action         = '0;
    logic [IN_KEY_BITS-1:0] i_entry_key      = '0;
    logic [QTY_BITS-1:0]    i_entry_quantity = '0;
    logic [STATUS_BITS-1:0] i_entry_status   = '0;
    logic                   o_valid;
    logic [CODE_BITS-1:0]   o_result_code;
    logic [QTY_BITS-1:0]    o_found_quantity;
    logic [STATUS_BITS-1:0] o_found_status;
    logic [HELD_BITS-1:0]   o_entries_held;

    // shadow copy of the stack contents
    logic [IN_KEY_BITS-1:0] shadow_key    [DEPTH];
    logic [QTY_BITS-1:0]    shadow_qty    [DEPTH];
    logic [STATUS_BITS-1:0] shadow_status [DEPTH];
    int unsigned            shadow_fill = 0;

    t_answer     pending_answers[$];
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;
    int unsigned sender_idle_pct = 0;
    bit          filling         = 1'b1;

    logic [IN_KEY_BITS-1:0] key_pool [8] = '{16'h0000, 16'hFFFF, 16'h00A5, 16'h5A00,
                                             16'h1234, 16'h8001, 16'h7FFE, 16'hC3C3};

    keyed_stack_with_search #(
        .STACK_DEPTH (DEF_STACK_DEPTH),
        .KEY_BITS    (DEF_KEY_BITS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_entry_key      (i_entry_key),
        .i_entry_quantity (i_entry_quantity),
        .i_entry_status   (i_entry_status),
        .o_valid          (o_valid),
        .o_result_code    (o_result_code),
        .o_found_quantity (o_found_quantity),
        .o_found_status   (o_found_status),
        .o_entries_held   (o_entries_held)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("keyed_stack_with_search_tb failed");
            $finish;
        end
    end

    // applies one command to the shadow stack and returns its answer
    function automatic t_answer predict_answer(t_action act, logic [IN_KEY_BITS-1:0] key,
                                               logic [QTY_BITS-1:0] qty,
                                               logic [STATUS_BITS-1:0] st);
        t_answer                ans;
        logic [IN_KEY_BITS-1:0] k;
        int                     slot;
        k    = key & KEY_MASK;
        ans  = '{code: RES_NOT_FOUND, qty: '0, status: '0, held: '0};
        slot = -1;
        // last hit in the upward scan is the one nearest the top
        for (int i = 0; i < int'(shadow_fill); i++) begin
            if (shadow_key[i] == k) slot = i;
        end
        case (act)
            ACT_PUSH: begin
                if (shadow_fill >= DEPTH) begin
                    ans.code = RES_FULL;
                end else begin
                    shadow_key[shadow_fill]    = k;
                    shadow_qty[shadow_fill]    = qty;
                    shadow_status[shadow_fill] = st;
                    shadow_fill++;
                    ans.code = RES_OK;
                end
            end
            ACT_UPDATE: begin
                if (slot >= 0) begin
                    shadow_status[slot] = st;
                    ans.code = RES_OK;
                end
            end
            ACT_POP: begin
                if (shadow_fill > 0 && shadow_key[shadow_fill-1] == k) begin
                    shadow_fill--;
                    ans.code = RES_OK;
                end
            end
            default: begin
                if (slot >= 0) begin
                    ans.qty    = shadow_qty[slot];
                    ans.status = shadow_status[slot];
                    ans.code   = RES_OK;
                end
            end
        endcase
        ans.held = HELD_BITS'(shadow_fill);
        return ans;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_answers.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, got code %0h held %0h",
                         $time, o_result_code, o_entries_held);
            end else begin
                want = pending_answers.pop_front();
                check_field("result_code", want.code, o_result_code);
                check_field("found_quantity", want.qty, o_found_quantity);
                check_field("found_status", want.status, o_found_status);
                check_field("entries_held", want.held, o_entries_held);
            end
        end
    end

    // start is left high on return so back-to-back items never toggle it
    // within one step; anything that lets time pass lowers it first
    task automatic send_cmd(t_action act, logic [IN_KEY_BITS-1:0] key,
                            logic [QTY_BITS-1:0] qty, logic [STATUS_BITS-1:0] st);
        int unsigned gap;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            gap = $urandom_range(24, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_action         <= act;
        i_entry_key      <= key;
        i_entry_quantity <= qty;
        i_entry_status   <= st;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_answers.push_back(predict_answer(act, key, qty, st));
    endtask

    task automatic drain_answers();
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [IN_KEY_BITS-1:0] pick_key(bit prefer_top);
        int unsigned r;
        r = $urandom_range(99);
        if (shadow_fill > 0 && prefer_top && r < 70) return shadow_key[shadow_fill-1];
        if (shadow_fill > 0 && r < 60) return shadow_key[$urandom_range(shadow_fill-1)];
        if (r < 90) return key_pool[$urandom_range(7)];
        return IN_KEY_BITS'($urandom_range(65535));
    endfunction

    task automatic test_empty_stack();
        send_cmd(ACT_LOOKUP, 16'h0000, 16'hFFFF, 2'd3);
        send_cmd(ACT_UPDATE, 16'hFFFF, 16'h0000, 2'd2);
        send_cmd(ACT_POP, 16'h0000, 16'h0000, 2'd0);
    endtask

    task automatic test_push_and_search();
        send_cmd(ACT_PUSH, 16'h0000, 16'h0000, 2'd0);
        send_cmd(ACT_PUSH, 16'hFFFF, 16'hFFFF, 2'd3);
        send_cmd(ACT_PUSH, 16'h0000, 16'h1234, 2'd1);
        // duplicate key: the newer entry answers
        send_cmd(ACT_LOOKUP, 16'h0000, 16'hAAAA, 2'd0);
        send_cmd(ACT_UPDATE, 16'h0000, 16'h5555, 2'd2);
        send_cmd(ACT_LOOKUP, 16'h0000, 16'h0000, 2'd3);
        send_cmd(ACT_POP, 16'hFFFF, 16'h0000, 2'd0);
        send_cmd(ACT_POP, 16'h0000, 16'h0000, 2'd0);
        send_cmd(ACT_LOOKUP, 16'h0000, 16'h0000, 2'd0);
        send_cmd(ACT_LOOKUP, 16'h5A5A, 16'h0000, 2'd0);
    endtask

    task automatic test_full_stack();
        int unsigned n;
        n = 0;
        while (shadow_fill < DEPTH) begin
            send_cmd(ACT_PUSH, 16'h1000 + IN_KEY_BITS'(n), QTY_BITS'($urandom_range(65535)),
                     STATUS_BITS'($urandom_range(3)));
            n++;
        end
        send_cmd(ACT_PUSH, 16'hBEEF, 16'hFFFF, 2'd3);
        // deep walks down to the bottom entry, and a miss over the whole stack
        send_cmd(ACT_LOOKUP, shadow_key[0], 16'h0000, 2'd0);
        send_cmd(ACT_UPDATE, shadow_key[0], 16'h0000, 2'd1);
        send_cmd(ACT_LOOKUP, 16'h7777, 16'h0000, 2'd0);
    endtask

    task automatic test_random_traffic(int unsigned count);
        int unsigned r;
        t_action     act;
        for (int unsigned i = 0; i < count; i++) begin
            if (shadow_fill == 0) filling = 1'b1;
            else if (shadow_fill == DEPTH && $urandom_range(3) == 0) filling = 1'b0;
            r = $urandom_range(99);
            if (filling) act = (r < 45) ? ACT_PUSH : (r < 60) ? ACT_POP :
                               (r < 80) ? ACT_LOOKUP : ACT_UPDATE;
            else act = (r < 10) ? ACT_PUSH : (r < 55) ? ACT_POP :
                       (r < 80) ? ACT_LOOKUP : ACT_UPDATE;
            send_cmd(act, pick_key(act == ACT_POP), QTY_BITS'($urandom_range(65535)),
                     STATUS_BITS'($urandom_range(3)));
            if (i == count / 2) drain_answers();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 9;
        test_empty_stack();
        test_push_and_search();
        test_full_stack();
        test_random_traffic(300);
        sender_idle_pct = 58;
        test_random_traffic(300);
        sender_idle_pct = 0;
        test_random_traffic(250);

        drain_answers();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("keyed_stack_with_search_tb passed");
        end else begin
            $display("keyed_stack_with_search_tb failed");
        end
        $finish;
    end

endmodule
